/* design/sprite_frame_sequencer_assert.svh */
// Assertion macros used by the sprite frame sequencer top level.
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on the rising edge, dropped during reset.
`define SFS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge, dropped during reset.
`define SFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sfs_pkg.sv */
// Types and constants shared by the sprite frame sequencer modules.
package sfs_pkg;

    localparam int FRAME_W = 8;
    localparam int FRAC_W  = 8;
    localparam int POS_W   = 19;   // signed Q10.8 frame position
    localparam int RATE_W  = 16;   // unsigned Q8.8 frames per time unit
    localparam int ELAP_W  = 8;
    localparam int INC_W   = 17;   // saturated increment, up to 511.0 frames
    localparam int OFFS_W  = 16;
    localparam int ADDR_W  = 3;

    // Increment ceiling: 511 frames in Q8.8
    localparam logic [INC_W-1:0] INC_MAX = 17'd130816;

    // Repeat modes
    localparam logic LOOP       = 1'b0;
    localparam logic ROUND_TRIP = 1'b1;

    // Configuration register indexes
    localparam logic [ADDR_W-1:0] REG_FIRST_FRAME = 3'd0;
    localparam logic [ADDR_W-1:0] REG_LAST_FRAME  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_SHEET_ROW   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_TILE_SIZE   = 3'd3;
    localparam logic [ADDR_W-1:0] REG_FRAME_RATE  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_REPEAT_MODE = 3'd5;
    localparam logic [ADDR_W-1:0] REG_WRAP_ENABLE = 3'd6;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PLAY  = 2'd1,
        OP_PAUSE = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    // Command beat after the increment has been formed
    typedef struct packed {
        t_op              op;
        logic [INC_W-1:0] inc;
    } t_cmd;

    // Settings the position stepper needs
    typedef struct packed {
        logic [FRAME_W-1:0] first_frame;
        logic [FRAME_W-1:0] last_frame;
        logic               repeat_mode;
        logic               wrap_enable;
    } t_step_cfg;

endpackage

/* design/sfs_inc_stage.sv */
// Input register: latches the command and the saturated frame increment.
module sfs_inc_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_advance,
    input  sfs_pkg::t_op                i_op,
    input  logic [sfs_pkg::ELAP_W-1:0]  i_elapsed,
    input  logic [sfs_pkg::RATE_W-1:0]  i_frame_rate,
    output logic                        o_valid,
    output sfs_pkg::t_cmd               o_cmd
);

    localparam int PROD_W = sfs_pkg::RATE_W + sfs_pkg::ELAP_W;

    logic                  r_valid;
    logic                  n_valid;
    sfs_pkg::t_cmd         r_cmd;
    sfs_pkg::t_cmd         n_cmd;
    logic [PROD_W-1:0]     prod;

    assign prod = i_frame_rate * i_elapsed;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_comb begin
        n_cmd    = r_cmd;
        if (i_load) begin
            n_cmd.op = i_op;
            // clip at 511 frames
            if (prod > PROD_W'(sfs_pkg::INC_MAX)) begin
                n_cmd.inc = sfs_pkg::INC_MAX;
            end else begin
                n_cmd.inc = prod[sfs_pkg::INC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

/* design/sfs_step.sv */
// Animation state: position, direction, play flag and shown frame, with the tick update.
module sfs_step (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sfs_pkg::t_step_cfg           i_cfg,
    input  logic                         i_first_wr,
    input  logic [sfs_pkg::FRAME_W-1:0]  i_first_data,
    input  logic                         i_fire,
    input  sfs_pkg::t_cmd                i_cmd,
    output logic [sfs_pkg::FRAME_W-1:0]  o_frame
);

    localparam int PW  = sfs_pkg::POS_W;
    localparam int EW  = PW + 1;
    localparam int WW  = PW - sfs_pkg::FRAC_W;   // whole-frame part width

    logic signed [PW-1:0]          r_pos;
    logic signed [PW-1:0]          n_pos;
    logic [sfs_pkg::FRAME_W-1:0]   r_shown;
    logic [sfs_pkg::FRAME_W-1:0]   n_shown;
    logic                          r_back;
    logic                          n_back;
    logic                          r_playing;
    logic                          n_playing;

    logic signed [EW-1:0]          pos_ext;
    logic signed [EW-1:0]          inc_ext;
    logic signed [EW-1:0]          sum;
    logic signed [EW-1:0]          dif;
    logic signed [PW-1:0]          sum_sat;
    logic signed [PW-1:0]          dif_sat;
    logic signed [EW-1:0]          upper;
    logic signed [EW-1:0]          lower;
    logic [sfs_pkg::FRAME_W:0]     last_p1;
    logic signed [sfs_pkg::FRAME_W+1:0] first_m1;
    logic signed [PW-1:0]          start_pos;
    logic signed [PW-1:0]          step_pos;
    logic                          step_back;
    logic signed [WW-1:0]          step_whole;
    logic signed [WW-1:0]          last_s;
    logic signed [WW-1:0]          first_s;
    logic signed [WW-1:0]          clip_hi;
    logic signed [WW-1:0]          clip_lo;

    assign pos_ext  = {r_pos[PW-1], r_pos};
    assign inc_ext  = signed'(EW'(i_cmd.inc));
    assign sum      = pos_ext + inc_ext;
    assign dif      = pos_ext - inc_ext;
    // saturate at the Q10.8 limits when the top two bits disagree
    assign sum_sat  = (sum[EW-1] != sum[EW-2]) ?
                      {sum[EW-1], {(PW-1){~sum[EW-1]}}} : sum[PW-1:0];
    assign dif_sat  = (dif[EW-1] != dif[EW-2]) ?
                      {dif[EW-1], {(PW-1){~dif[EW-1]}}} : dif[PW-1:0];

    assign last_p1  = {1'b0, i_cfg.last_frame} + 1'b1;
    assign first_m1 = signed'({2'b00, i_cfg.first_frame}) - 10'sd1;
    assign upper    = signed'({{(EW-sfs_pkg::FRAME_W-1-sfs_pkg::FRAC_W){1'b0}},
                               last_p1, {sfs_pkg::FRAC_W{1'b0}}});
    assign lower    = signed'({{(EW-sfs_pkg::FRAME_W-2-sfs_pkg::FRAC_W){first_m1[sfs_pkg::FRAME_W+1]}},
                               first_m1, {sfs_pkg::FRAC_W{1'b0}}});
    assign start_pos = signed'({{(PW-sfs_pkg::FRAME_W-sfs_pkg::FRAC_W){1'b0}},
                                i_cfg.first_frame, {sfs_pkg::FRAC_W{1'b0}}});

    // Position and direction after one playing tick
    always_comb begin
        step_pos  = r_pos;
        step_back = r_back;
        unique case (i_cfg.repeat_mode)
            sfs_pkg::LOOP: begin
                if (pos_ext < upper) begin
                    step_pos = sum_sat;
                end else if (i_cfg.wrap_enable) begin
                    step_pos = start_pos;
                end
            end
            sfs_pkg::ROUND_TRIP: begin
                if (!r_back && (pos_ext < upper)) begin
                    step_pos = sum_sat;
                end else if (pos_ext > lower) begin
                    // turning at the top end also steps back in this tick
                    step_pos  = dif_sat;
                    step_back = 1'b1;
                end else begin
                    step_back = 1'b0;
                end
            end
            default: begin
                step_pos  = r_pos;
                step_back = r_back;
            end
        endcase
    end

    assign last_s  = signed'(WW'(i_cfg.last_frame));
    assign first_s = signed'(WW'(i_cfg.first_frame));

    // An arithmetic shift rounds negatives down instead of toward zero; either
    // way the value sits below first_frame and clamps to it.
    assign step_whole = step_pos[PW-1:sfs_pkg::FRAC_W];
    assign clip_hi    = (step_whole > last_s) ? last_s : step_whole;
    assign clip_lo    = (clip_hi < first_s) ? first_s : clip_hi;

    always_comb begin
        n_pos     = r_pos;
        n_back    = r_back;
        n_playing = r_playing;
        n_shown   = r_shown;
        if (i_first_wr) begin
            n_pos   = signed'({{(PW-sfs_pkg::FRAME_W-sfs_pkg::FRAC_W){1'b0}},
                               i_first_data, {sfs_pkg::FRAC_W{1'b0}}});
            n_shown = i_first_data;
        end else if (i_fire) begin
            unique case (i_cmd.op)
                sfs_pkg::OP_TICK: begin
                    if (r_playing) begin
                        n_pos   = step_pos;
                        n_back  = step_back;
                        n_shown = clip_lo[sfs_pkg::FRAME_W-1:0];
                    end
                end
                sfs_pkg::OP_PLAY: begin
                    n_playing = 1'b1;
                end
                sfs_pkg::OP_PAUSE: begin
                    n_playing = 1'b0;
                end
                sfs_pkg::OP_STOP: begin
                    n_playing = 1'b0;
                    n_shown   = i_cfg.first_frame;
                end
                default: begin
                    n_playing = r_playing;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_shown   <= '0;
            r_back    <= 1'b0;
            r_playing <= 1'b1;
        end else begin
            r_pos     <= n_pos;
            r_shown   <= n_shown;
            r_back    <= n_back;
            r_playing <= n_playing;
        end
    end

    // Frame shown after this tick (unchanged while paused)
    assign o_frame = n_shown;

endmodule

/* design/sprite_frame_sequencer.sv */
// Top level of the sprite frame sequencer: config registers, handshake and result register.
//
// Steps a sprite animation through the frames of one tile-sheet row. Each input
// beat carries a command in s_axis_tuser (0 tick, 1 play, 2 pause, 3 stop) and the
// elapsed time in s_axis_tdata. A tick adds frame_rate * elapsed (Q8.8, clipped at
// 511 frames) to a signed Q10.8 frame position, loops or bounces between
// first_frame and last_frame, and yields one result beat: the shown frame and its
// pixel offsets (frame * tile_size, sheet_row * tile_size). While paused or stopped
// a tick repeats the shown frame. Play, pause and stop yield no result beat; stop
// also shows first_frame. Writing first_frame reloads the position.
// Timing: one beat per clock, sustained while no tick waits in the input register. A
// beat is held in the input register, where the increment multiplier result is
// captured, and the position update plus frame clamp run from there into the result
// register, so a tick's result reaches m_axis through the input register and then the
// result register. The result register holds a stalled beat while the input register
// keeps taking new commands; only a tick that finds it full and not draining waits.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_wdata, by the user only
// while no beat is in flight (the block does not enforce it); index 0..6 in the order
// first_frame, last_frame, sheet_row, tile_size, frame_rate, repeat_mode, wrap_enable.
module sprite_frame_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] elapsed
    input  logic [1:0]                   s_axis_tuser,   // [1:0] opcode
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [39:0]                  m_axis_tdata,   // [7:0] frame_index,
                                                         // [23:8] x_offset,
                                                         // [39:24] y_offset
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [sfs_pkg::ADDR_W-1:0]   i_cfg_addr,
    input  logic [sfs_pkg::RATE_W-1:0]   i_cfg_wdata
);

`include "sprite_frame_sequencer_assert.svh"

    // configuration registers
    logic [sfs_pkg::FRAME_W-1:0]  r_first_frame;
    logic [sfs_pkg::FRAME_W-1:0]  r_last_frame;
    logic [sfs_pkg::FRAME_W-1:0]  r_sheet_row;
    logic [sfs_pkg::FRAME_W-1:0]  r_tile_size;
    logic [sfs_pkg::RATE_W-1:0]   r_frame_rate;
    logic                         r_repeat_mode;
    logic                         r_wrap_enable;

    // result register
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [sfs_pkg::FRAME_W-1:0]  r_out_frame;
    logic [sfs_pkg::FRAME_W-1:0]  n_out_frame;

    logic                         in_load;
    logic                         cmd_valid;
    sfs_pkg::t_cmd                cmd;
    logic                         cmd_is_tick;
    logic                         out_free;
    logic                         cmd_fire;
    logic                         first_wr;
    sfs_pkg::t_step_cfg           step_cfg;
    logic [sfs_pkg::FRAME_W-1:0]  step_frame;
    logic [sfs_pkg::OFFS_W-1:0]   x_offset;
    logic [sfs_pkg::OFFS_W-1:0]   y_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_frame <= '0;
            r_last_frame  <= '0;
            r_sheet_row   <= '0;
            r_tile_size   <= 8'd16;
            r_frame_rate  <= 16'd256;
            r_repeat_mode <= sfs_pkg::LOOP;
            r_wrap_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sfs_pkg::REG_FIRST_FRAME: r_first_frame <= i_cfg_wdata[sfs_pkg::FRAME_W-1:0];
                sfs_pkg::REG_LAST_FRAME:  r_last_frame  <= i_cfg_wdata[sfs_pkg::FRAME_W-1:0];
                sfs_pkg::REG_SHEET_ROW:   r_sheet_row   <= i_cfg_wdata[sfs_pkg::FRAME_W-1:0];
                sfs_pkg::REG_TILE_SIZE:   r_tile_size   <= i_cfg_wdata[sfs_pkg::FRAME_W-1:0];
                sfs_pkg::REG_FRAME_RATE:  r_frame_rate  <= i_cfg_wdata;
                sfs_pkg::REG_REPEAT_MODE: r_repeat_mode <= i_cfg_wdata[0];
                sfs_pkg::REG_WRAP_ENABLE: r_wrap_enable <= i_cfg_wdata[0];
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    assign first_wr = i_cfg_we && (i_cfg_addr == sfs_pkg::REG_FIRST_FRAME);

    // Handshake: the result register frees up when empty or being taken; a
    // command leaves the input register unless it is a tick that has no room.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign cmd_is_tick   = (cmd.op == sfs_pkg::OP_TICK);
    assign cmd_fire      = cmd_valid && (!cmd_is_tick || out_free);
    assign s_axis_tready = !cmd_valid || cmd_fire;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    sfs_inc_stage u_inc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_load),
        .i_advance    (cmd_fire),
        .i_op         (sfs_pkg::t_op'(s_axis_tuser)),
        .i_elapsed    (s_axis_tdata),
        .i_frame_rate (r_frame_rate),
        .o_valid      (cmd_valid),
        .o_cmd        (cmd)
    );

    assign step_cfg.first_frame = r_first_frame;
    assign step_cfg.last_frame  = r_last_frame;
    assign step_cfg.repeat_mode = r_repeat_mode;
    assign step_cfg.wrap_enable = r_wrap_enable;

    sfs_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (step_cfg),
        .i_first_wr   (first_wr),
        .i_first_data (i_cfg_wdata[sfs_pkg::FRAME_W-1:0]),
        .i_fire       (cmd_fire),
        .i_cmd        (cmd),
        .o_frame      (step_frame)
    );

    // Load a result on every tick that leaves the input register; hold otherwise.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_frame = r_out_frame;
        if (cmd_fire && cmd_is_tick) begin
            n_out_valid = 1'b1;
            n_out_frame = step_frame;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_frame <= n_out_frame;
    end

    // Offsets come from registered values; a stalled beat keeps its offsets if the user
    // holds tile_size and sheet_row while a beat is pending (not enforced here).
    assign x_offset = r_out_frame * r_tile_size;
    assign y_offset = r_sheet_row * r_tile_size;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {y_offset, x_offset, r_out_frame};

    // a non-tick command never produces a result beat
    `SFS_ASSERT_NEXT(a_no_result_for_cmd, i_clk, i_rst_n,
        !r_out_valid && cmd_valid && !cmd_is_tick, !r_out_valid,
        "play/pause/stop produced a result beat")
    // a tick that leaves the input register shows up as a result next cycle
    `SFS_ASSERT_NEXT(a_tick_gives_result, i_clk, i_rst_n,
        cmd_fire && cmd_is_tick, r_out_valid,
        "tick did not load the result register")
    // a tick blocked by a full result register stays in the input register
    `SFS_ASSERT_NEXT(a_blocked_tick_held, i_clk, i_rst_n,
        cmd_valid && cmd_is_tick && !out_free, cmd_valid && cmd_is_tick,
        "blocked tick was lost from the input register")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the sprite frame sequencer: directed and random command streams.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF   = 5;
    localparam int RST_CYCLES = 11;
    localparam int SETTLE     = 6;        // idle wait that lets commands without results retire
    localparam int CYCLE_CAP  = 500000;
    localparam int PHASES     = 14;
    localparam int PHASE_LEN  = 128;
    localparam int STALL_LEN  = 150;
    localparam int STALL_BEATS = 40;
    localparam int POS_HI     = 262143;   // signed Q10.8 limits of the frame position
    localparam int POS_LO     = -262144;

    // One result beat: shown frame and its tile offsets
    typedef struct packed {
        logic [sfs_pkg::FRAME_W-1:0] frame;
        logic [sfs_pkg::OFFS_W-1:0]  x_off;
        logic [sfs_pkg::OFFS_W-1:0]  y_off;
    } t_frame_view;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata = '0;    // [7:0] elapsed
    logic [1:0]                   s_axis_tuser = '0;    // [1:0] opcode
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [39:0]                  m_axis_tdata;         // [7:0] frame, [23:8] x, [39:24] y
    logic                         i_cfg_we = 1'b0;
    logic [sfs_pkg::ADDR_W-1:0]   i_cfg_addr = '0;
    logic [sfs_pkg::RATE_W-1:0]   i_cfg_wdata = '0;

    // Mirror of the register file, at reset values
    logic [sfs_pkg::FRAME_W-1:0]  reg_first = 8'd0;
    logic [sfs_pkg::FRAME_W-1:0]  reg_last  = 8'd0;
    logic [sfs_pkg::FRAME_W-1:0]  reg_row   = 8'd0;
    logic [sfs_pkg::FRAME_W-1:0]  reg_tile  = 8'd16;
    logic [sfs_pkg::RATE_W-1:0]   reg_rate  = 16'd256;
    logic                         reg_mode  = sfs_pkg::LOOP;
    logic                         reg_wrap  = 1'b1;

    // Mirror of the animation state
    int                           anim_pos = 0;         // Q10.8, clipped to 19-bit signed range
    logic [sfs_pkg::FRAME_W-1:0]  anim_shown = 8'd0;
    logic                         anim_backward = 1'b0;
    logic                         anim_running = 1'b1;

    t_frame_view          frames_due[$];
    t_frame_view          got_beat;
    t_frame_view          want_beat;
    int                   mismatches = 0;
    int                   cycles = 0;

    // Knobs for the idling on both sides
    bit                   tx_gaps = 1'b1;
    bit                   rx_stalls = 1'b1;
    int                   hold_req = 0;

    sprite_frame_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Kill a hung run
    initial begin
        while (cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int clip_pos(input int v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    // Advance the animation mirror by one command; returns 1 when a result beat is due.
    function automatic bit advance_sprite(input sfs_pkg::t_op op, input logic [7:0] el,
                                          output t_frame_view v);
        int step;
        int upper;
        int lower;
        int whole;
        v = '0;
        case (op)
            sfs_pkg::OP_PLAY: begin
                anim_running = 1'b1;
                return 1'b0;
            end
            sfs_pkg::OP_PAUSE: begin
                anim_running = 1'b0;
                return 1'b0;
            end
            sfs_pkg::OP_STOP: begin
                // show the first frame but keep the position
                anim_running = 1'b0;
                anim_shown   = reg_first;
                return 1'b0;
            end
            default: ;
        endcase

        // a tick while halted just repeats the shown frame
        if (anim_running) begin
            step = int'(reg_rate) * int'(el);
            if (step > int'(sfs_pkg::INC_MAX)) step = int'(sfs_pkg::INC_MAX);
            upper = (int'(reg_last) + 1) * 256;
            lower = (int'(reg_first) - 1) * 256;
            if (reg_mode == sfs_pkg::LOOP) begin
                if (anim_pos < upper) anim_pos = clip_pos(anim_pos + step);
                else if (reg_wrap) anim_pos = int'(reg_first) * 256;
            end else begin
                // a flip at the top end may subtract in the same tick
                if (!anim_backward) begin
                    if (anim_pos < upper) anim_pos = clip_pos(anim_pos + step);
                    else anim_backward = 1'b1;
                end
                if (anim_backward) begin
                    if (anim_pos > lower) anim_pos = clip_pos(anim_pos - step);
                    else anim_backward = 1'b0;
                end
            end
            // truncate toward zero, clamp to last first so first wins
            whole = anim_pos / 256;
            if (whole > int'(reg_last)) whole = int'(reg_last);
            if (whole < int'(reg_first)) whole = int'(reg_first);
            anim_shown = whole[7:0];
        end
        v.frame = anim_shown;
        v.x_off = {8'd0, anim_shown} * {8'd0, reg_tile};
        v.y_off = {8'd0, reg_row} * {8'd0, reg_tile};
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (!tx_gaps) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 9);
        return $urandom_range(12, 20);
    endfunction

    // Offer one command beat, hold it until taken, then idle for a random gap.
    task automatic send_cmd(input sfs_pkg::t_op op, input logic [7:0] el);
        t_frame_view v;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= el;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (advance_sprite(op, el, v)) frames_due.push_back(v);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write one register while the block is idle and mirror it.
    task automatic write_reg(input logic [sfs_pkg::ADDR_W-1:0] idx,
                             input logic [sfs_pkg::RATE_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            sfs_pkg::REG_FIRST_FRAME: begin
                // reload position and shown frame
                reg_first  = val[7:0];
                anim_pos   = int'(val[7:0]) * 256;
                anim_shown = val[7:0];
            end
            sfs_pkg::REG_LAST_FRAME:  reg_last = val[7:0];
            sfs_pkg::REG_SHEET_ROW:   reg_row  = val[7:0];
            sfs_pkg::REG_TILE_SIZE:   reg_tile = val[7:0];
            sfs_pkg::REG_FRAME_RATE:  reg_rate = val;
            sfs_pkg::REG_REPEAT_MODE: reg_mode = val[0];
            sfs_pkg::REG_WRAP_ENABLE: reg_wrap = val[0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, wait out every expected beat, then let commands without results retire.
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Out of reset: single-frame loop, wrap, pause/stop/play around ticks.
    task automatic test_reset_defaults();
        send_cmd(sfs_pkg::OP_TICK, 8'd0);
        send_cmd(sfs_pkg::OP_TICK, 8'd1);
        send_cmd(sfs_pkg::OP_TICK, 8'd255);     // past the end, wraps to first
        send_cmd(sfs_pkg::OP_PAUSE, 8'd0);
        send_cmd(sfs_pkg::OP_TICK, 8'd7);       // paused: repeat
        send_cmd(sfs_pkg::OP_PLAY, 8'd255);
        send_cmd(sfs_pkg::OP_TICK, 8'd3);
        send_cmd(sfs_pkg::OP_STOP, 8'd0);
        send_cmd(sfs_pkg::OP_TICK, 8'd255);     // stopped: first frame again
        send_cmd(sfs_pkg::OP_PLAY, 8'd0);
    endtask

    // Top of the frame range, full rate, saturated step, wrap off, zero rate.
    task automatic test_extremes();
        wait_for_idle();
        write_reg(sfs_pkg::REG_FIRST_FRAME, 16'd250);
        write_reg(sfs_pkg::REG_LAST_FRAME, 16'd255);
        write_reg(sfs_pkg::REG_SHEET_ROW, 16'd255);
        write_reg(sfs_pkg::REG_TILE_SIZE, 16'd255);
        write_reg(sfs_pkg::REG_FRAME_RATE, 16'hFFFF);
        write_reg(sfs_pkg::REG_WRAP_ENABLE, 16'd0);
        send_cmd(sfs_pkg::OP_TICK, 8'd255);     // step clips at 511 frames
        send_cmd(sfs_pkg::OP_TICK, 8'd0);       // past the end without wrap: hold
        send_cmd(sfs_pkg::OP_TICK, 8'd128);
        wait_for_idle();
        write_reg(sfs_pkg::REG_FRAME_RATE, 16'd0);
        send_cmd(sfs_pkg::OP_TICK, 8'd200);
    endtask

    // Bounce between the ends, then an inverted range where first wins.
    task automatic test_bounce_mode();
        wait_for_idle();
        write_reg(sfs_pkg::REG_REPEAT_MODE, 16'(sfs_pkg::ROUND_TRIP));
        write_reg(sfs_pkg::REG_WRAP_ENABLE, 16'd1);
        write_reg(sfs_pkg::REG_LAST_FRAME, 16'd4);
        write_reg(sfs_pkg::REG_FIRST_FRAME, 16'd2);
        write_reg(sfs_pkg::REG_TILE_SIZE, 16'd9);
        write_reg(sfs_pkg::REG_SHEET_ROW, 16'd3);
        write_reg(sfs_pkg::REG_FRAME_RATE, 16'd384);
        repeat (7) send_cmd(sfs_pkg::OP_TICK, 8'd1);
        wait_for_idle();
        write_reg(sfs_pkg::REG_FIRST_FRAME, 16'd9);
        write_reg(sfs_pkg::REG_LAST_FRAME, 16'd3);
        write_reg(sfs_pkg::REG_TILE_SIZE, 16'd0);
        send_cmd(sfs_pkg::OP_TICK, 8'd2);
        send_cmd(sfs_pkg::OP_TICK, 8'd5);
    endtask

    // Hold the result side off for a long stretch while ticks keep coming.
    task automatic test_output_stall();
        wait_for_idle();
        write_reg(sfs_pkg::REG_REPEAT_MODE, 16'(sfs_pkg::LOOP));
        write_reg(sfs_pkg::REG_FIRST_FRAME, 16'd0);
        write_reg(sfs_pkg::REG_LAST_FRAME, 16'd15);
        write_reg(sfs_pkg::REG_TILE_SIZE, 16'd32);
        write_reg(sfs_pkg::REG_FRAME_RATE, 16'd200);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        hold_req  = STALL_LEN;
        repeat (STALL_BEATS) send_cmd(sfs_pkg::OP_TICK, 8'($urandom_range(0, 4)));
        wait_for_idle();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // Random settings per phase; extremes show up now and then.
    task automatic shuffle_settings(input bit write_all);
        int roll;
        logic [7:0] first;
        logic [7:0] last;
        logic [15:0] rate;
        logic [7:0] tile;
        roll = $urandom_range(0, 9);
        first = 8'($urandom_range(0, 40));
        last  = first + 8'($urandom_range(0, 12));
        case (roll)
            0: begin first = 8'd0;   last = 8'd0;   end
            1: begin first = 8'd255; last = 8'd255; end
            2: begin first = 8'd0;   last = 8'd255; end
            3: begin
                first = 8'($urandom_range(1, 255));
                last  = 8'($urandom_range(0, first - 1));
            end
            default: ;
        endcase
        roll = $urandom_range(0, 9);
        rate = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom_range(16, 768));
        roll = $urandom_range(0, 9);
        tile = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom_range(0, 255));

        if (write_all || $urandom_range(0, 1))
            write_reg(sfs_pkg::REG_FIRST_FRAME, {8'd0, first});
        if (write_all || $urandom_range(0, 3) != 0)
            write_reg(sfs_pkg::REG_LAST_FRAME, {8'd0, last});
        if (write_all || $urandom_range(0, 1))
            write_reg(sfs_pkg::REG_SHEET_ROW, 16'($urandom_range(0, 255)));
        if (write_all || $urandom_range(0, 1))
            write_reg(sfs_pkg::REG_TILE_SIZE, {8'd0, tile});
        if (write_all || $urandom_range(0, 3) != 0)
            write_reg(sfs_pkg::REG_FRAME_RATE, rate);
        if (write_all || $urandom_range(0, 1))
            write_reg(sfs_pkg::REG_REPEAT_MODE, 16'($urandom_range(0, 1)));
        if (write_all || $urandom_range(0, 1))
            write_reg(sfs_pkg::REG_WRAP_ENABLE, 16'($urandom_range(0, 1)));
    endtask

    // Mostly ticks while playing; halted animations get restarted soon.
    task automatic test_random_phases();
        sfs_pkg::t_op op;
        logic [7:0] el;
        int roll;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_for_idle();
            tx_gaps   = (ph % 4 != 1);
            rx_stalls = (ph % 4 != 1) && (ph % 4 != 2);
            shuffle_settings(ph == 0);
            for (int n = 0; n < PHASE_LEN; n++) begin
                roll = $urandom_range(0, 99);
                if (!anim_running) begin
                    if (roll < 40) op = sfs_pkg::OP_PLAY;
                    else if (roll < 45) op = sfs_pkg::OP_STOP;
                    else if (roll < 50) op = sfs_pkg::OP_PAUSE;
                    else op = sfs_pkg::OP_TICK;
                end else begin
                    if (roll < 88) op = sfs_pkg::OP_TICK;
                    else if (roll < 93) op = sfs_pkg::OP_PLAY;
                    else if (roll < 96) op = sfs_pkg::OP_PAUSE;
                    else op = sfs_pkg::OP_STOP;
                end
                el = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 6));
                send_cmd(op, el);
            end
        end
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        int stall_left;
        logic rdy;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 99) < 20) begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24)
                                                          : $urandom_range(0, 2);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_axis_tready <= rdy;
        end
    end

    // Compare every accepted result beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_beat.frame = m_axis_tdata[7:0];
            got_beat.x_off = m_axis_tdata[23:8];
            got_beat.y_off = m_axis_tdata[39:24];
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: frame %0d x %0d y %0d",
                             got_beat.frame, got_beat.x_off, got_beat.y_off);
            end else begin
                want_beat = frames_due.pop_front();
                if (got_beat != want_beat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want f %0d x %0d y %0d, got f %0d x %0d y %0d",
                                 want_beat.frame, want_beat.x_off, want_beat.y_off,
                                 got_beat.frame, got_beat.x_off, got_beat.y_off);
                end
            end
        end
    end

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_extremes();
        test_bounce_mode();
        test_output_stall();
        test_random_phases();
        wait_for_idle();
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/sfs_pkg.sv
design/sfs_inc_stage.sv
design/sfs_step.sv
design/sprite_frame_sequencer.sv
dv/testbench.sv
